// ===== src/als_pkg.sv =====
// als_pkg: shared types and constants of the anti-aliased line stepper
// no dependencies; used by als_if, als_div and antialiased_line_stepper
`default_nettype none

package als_pkg;

  localparam int unsigned CoordW = 20;   // Q12.8 endpoint coordinate
  localparam int unsigned MinorW = 28;   // Q12.16 minor position
  localparam int unsigned SlopeW = 18;   // Q1.16 signed slope
  localparam int unsigned QuoW   = 17;   // unsigned slope magnitude
  localparam int unsigned SpanW  = 21;   // span between two endpoints
  localparam int unsigned PixW   = 10;
  localparam int unsigned ShadeW = 32;
  localparam int unsigned CovW   = 8;
  localparam int unsigned IntW   = 14;   // signed integer pixel coordinate

  localparam logic [ShadeW-1:0] ShadeReset = 32'h0001_0101;
  localparam logic [CovW-1:0]   FullCover  = 8'hFF;

  localparam logic signed [IntW-1:0] RasterW = 14'sd1024;
  localparam logic signed [IntW-1:0] RasterH = 14'sd1024;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncStep = 1'b1;

  // request to the serial divider: slope magnitude = num * 2^16 / den, num <= den
  typedef struct packed {
    logic             start;
    logic [SpanW-1:0] num;
    logic [SpanW-1:0] den;
  } div_req_t;

endpackage

`default_nettype wire

// ===== src/als_if.sv =====
// als_in_if / als_out_if: valid-ready channels of the line stepper
// depends on als_pkg for field widths
`default_nettype none

interface als_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic signed [als_pkg::CoordW-1:0]   start_x;
  logic signed [als_pkg::CoordW-1:0]   start_y;
  logic signed [als_pkg::CoordW-1:0]   end_x;
  logic signed [als_pkg::CoordW-1:0]   end_y;

  modport source (output valid, func, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, func, start_x, start_y, end_x, end_y, output ready);
endinterface

interface als_out_if;
  logic                         valid;
  logic                         ready;
  logic [als_pkg::PixW-1:0]     pix_x;
  logic [als_pkg::PixW-1:0]     pix_y;
  logic [als_pkg::ShadeW-1:0]   near_value;
  logic [als_pkg::ShadeW-1:0]   far_value;
  logic                         far_ok;
  logic                         along_x;
  logic                         plotted;
  logic                         last;

  modport source (output valid, pix_x, pix_y, near_value, far_value, far_ok, along_x,
                  plotted, last, input ready);
  modport sink   (input valid, pix_x, pix_y, near_value, far_value, far_ok, along_x,
                  plotted, last, output ready);
endinterface

`default_nettype wire

// ===== src/als_div.sv =====
// als_div: restoring divider, one quotient bit per cycle
// depends on als_pkg (div_req_t, widths)
`default_nettype none

module als_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire als_pkg::div_req_t          req_i,
  output logic                            done_o,
  output logic [als_pkg::QuoW-1:0]        quo_o
);

  logic                          busy_q;
  logic [4:0]                    cnt_q;
  logic [als_pkg::SpanW:0]       rem_q, rem_d;
  logic [als_pkg::SpanW-1:0]     den_q;
  logic [als_pkg::QuoW-1:0]      quo_q;
  logic                          done_q;
  logic [als_pkg::SpanW:0]       shifted;
  logic [als_pkg::SpanW+1:0]     diff;
  logic                          qbit;

  // first step compares num itself, since the top quotient bit weighs 2^16
  always_comb begin
    shifted = (cnt_q == 5'd0) ? rem_q : {rem_q[als_pkg::SpanW-1:0], 1'b0};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    qbit    = ~diff[als_pkg::SpanW+1];
    rem_d   = qbit ? diff[als_pkg::SpanW:0] : shifted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(als_pkg::QuoW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {1'b0, req_i.num};
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[als_pkg::QuoW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== src/antialiased_line_stepper.sv =====
// antialiased_line_stepper: Wu-style anti-aliased line column generator
// depends on als_pkg, als_if (als_in_if, als_out_if) and als_div
//
// Usage: a load beat (func 0) on in_i carries two Q12.8 endpoints; it gives
// no output beat. The block orders the endpoints along the major axis and
// derives the Q1.16 slope with a serial divider; a load occupies the block
// through the accepting cycle, the ordering state, the divider run and the
// store of the slope. Each step beat (func 1), while a line is active,
// advances one column and produces one beat on out_o with the near and far
// pixel weights; a step runs through the accepting cycle, position update,
// pixel geometry, then two passes through the one shared 32x8 multiplier
// for the near and far weights, and its beat is registered into out_o.
// A step with no active line gives no beat and leaves the block idle.
// in_i.ready is high only while the sequencer is idle. The result sits in
// an output register, so the next beat is taken while out_o waits; if the
// receiver still holds the previous beat when the next result is ready, the
// block waits in its final multiply cycle.
// shade_i is written when shade_we_i is high; write it only while idle.
// Reset clears the active line and sets shade to 0x010101.
`default_nettype none

module antialiased_line_stepper (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        shade_we_i,
  input  wire logic [als_pkg::ShadeW-1:0]  shade_i,
  als_in_if.sink                           in_i,
  als_out_if.source                        out_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_ORDER, S_DIV, S_ADV, S_GEOM, S_NEAR, S_FAR
  } state_e;

  state_e state_q;

  logic [als_pkg::ShadeW-1:0]          shade_q;
  logic                                active_q;
  logic                                steep_q;
  logic signed [als_pkg::CoordW-1:0]   major_pos_q;
  logic signed [als_pkg::MinorW-1:0]   minor_pos_q;
  logic signed [als_pkg::CoordW-1:0]   major_end_q;
  logic signed [als_pkg::SlopeW-1:0]   slope_q;

  // load setup registers
  logic signed [als_pkg::CoordW-1:0]   sx_q, sy_q, ex_q, ey_q;
  logic signed [als_pkg::SpanW-1:0]    dx_q, dy_q;
  logic                                neg_q;
  logic                                zero_q;

  // step registers
  logic                                last_q;
  logic [als_pkg::CovW-1:0]            cov_q;
  logic [als_pkg::PixW-1:0]            px_q, py_q;
  logic                                plot_q, far_ok_q;
  logic [als_pkg::ShadeW-1:0]          near_q;

  // output register
  logic                                ovalid_q;
  logic [als_pkg::PixW-1:0]            opx_q, opy_q;
  logic [als_pkg::ShadeW-1:0]          onear_q, ofar_q;
  logic                                ofar_ok_q, oalong_q, oplot_q, olast_q;

  logic in_fire, out_free;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !ovalid_q || out_o.ready;

  logic ovalid_d;
  always_comb begin
    ovalid_d = ovalid_q && !out_o.ready;
    if (state_q == S_FAR && out_free) begin
      ovalid_d = 1'b1;
    end
  end

  // ordering of a loaded line along the major axis
  logic signed [als_pkg::SpanW-1:0] adx, ady, d_major, d_minor;
  logic [als_pkg::SpanW-1:0]        dma, admi;
  logic                             steep, swap;
  always_comb begin
    adx     = dx_q[als_pkg::SpanW-1] ? -dx_q : dx_q;
    ady     = dy_q[als_pkg::SpanW-1] ? -dy_q : dy_q;
    steep   = ady > adx;
    d_major = steep ? dy_q : dx_q;
    d_minor = steep ? dx_q : dy_q;
    swap    = d_major[als_pkg::SpanW-1];
    dma     = swap ? -d_major : d_major;
    admi    = d_minor[als_pkg::SpanW-1] ? -d_minor : d_minor;
  end

  als_pkg::div_req_t           div_req;
  logic                        div_done;
  logic [als_pkg::QuoW-1:0]    div_quo;
  assign div_req.start = (state_q == S_ORDER);
  assign div_req.num   = admi;
  assign div_req.den   = dma;

  als_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // column advance
  logic signed [als_pkg::SpanW-1:0]  next_major;
  logic                              next_last;
  always_comb begin
    next_major = {major_pos_q[als_pkg::CoordW-1], major_pos_q} + 21'sd256;
    next_last  = next_major >= $signed({major_end_q[als_pkg::CoordW-1], major_end_q});
  end

  // pixel geometry from the advanced positions
  logic signed [als_pkg::IntW-1:0] maj_i, min_i, gx, gy, gfx, gfy;
  logic [23:0]                     cov_w;
  logic                            g_plot, g_far;
  always_comb begin
    maj_i  = als_pkg::IntW'($signed(major_pos_q[als_pkg::CoordW-1:8]));
    min_i  = als_pkg::IntW'($signed(minor_pos_q[als_pkg::MinorW-1:16]));
    gx     = steep_q ? min_i : maj_i;
    gy     = steep_q ? maj_i : min_i;
    gfx    = gx + 14'sd1;
    gfy    = gy + 14'sd1;
    g_plot = !gx[als_pkg::IntW-1] && (gx < als_pkg::RasterW) &&
             !gy[als_pkg::IntW-1] && (gy < als_pkg::RasterH);
    g_far  = g_plot && (steep_q ? (gfx < als_pkg::RasterW) : (gfy < als_pkg::RasterH));
    // 255 * frac / 2^16 as shift and subtract
    cov_w  = {minor_pos_q[15:0], 8'h00} - {8'h00, minor_pos_q[15:0]};
  end

  // shared multiplier: near weight then far weight
  logic [als_pkg::CovW-1:0]   mul_a;
  logic [als_pkg::ShadeW-1:0] mul_p;
  always_comb begin
    mul_a = (state_q == S_NEAR) ? (als_pkg::FullCover - cov_q) : cov_q;
    mul_p = als_pkg::ShadeW'(mul_a * shade_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      shade_q     <= als_pkg::ShadeReset;
      active_q    <= 1'b0;
      steep_q     <= 1'b0;
      major_pos_q <= '0;
      minor_pos_q <= '0;
      major_end_q <= '0;
      slope_q     <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      if (shade_we_i) begin
        shade_q <= shade_i;
      end
      ovalid_q <= ovalid_d;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_i.func == als_pkg::FuncLoad) begin
              state_q <= S_ORDER;
            end else if (active_q) begin
              state_q <= S_ADV;
            end
          end
        end
        S_ORDER: begin
          steep_q     <= steep;
          major_pos_q <= swap ? (steep ? ey_q : ex_q) : (steep ? sy_q : sx_q);
          major_end_q <= swap ? (steep ? sy_q : sx_q) : (steep ? ey_q : ex_q);
          minor_pos_q <= {(swap ? (steep ? ex_q : ey_q) : (steep ? sx_q : sy_q)), 8'h00};
          active_q    <= (dma != '0);
          state_q     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (zero_q) begin
              slope_q <= '0;
            end else if (neg_q) begin
              slope_q <= -$signed({1'b0, div_quo});
            end else begin
              slope_q <= $signed({1'b0, div_quo});
            end
            state_q <= S_IDLE;
          end
        end
        S_ADV: begin
          major_pos_q <= next_major[als_pkg::CoordW-1:0];
          minor_pos_q <= minor_pos_q + als_pkg::MinorW'(slope_q);
          if (next_last) begin
            active_q <= 1'b0;
          end
          state_q <= S_GEOM;
        end
        S_GEOM: begin
          state_q <= S_NEAR;
        end
        S_NEAR: begin
          state_q <= S_FAR;
        end
        S_FAR: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sx_q <= in_i.start_x;
      sy_q <= in_i.start_y;
      ex_q <= in_i.end_x;
      ey_q <= in_i.end_y;
      dx_q <= {in_i.end_x[als_pkg::CoordW-1], in_i.end_x} -
              {in_i.start_x[als_pkg::CoordW-1], in_i.start_x};
      dy_q <= {in_i.end_y[als_pkg::CoordW-1], in_i.end_y} -
              {in_i.start_y[als_pkg::CoordW-1], in_i.start_y};
    end
    if (state_q == S_ORDER) begin
      neg_q  <= d_minor[als_pkg::SpanW-1] ^ swap;
      zero_q <= (dma == '0);
    end
    if (state_q == S_ADV) begin
      last_q <= next_last;
    end
    if (state_q == S_GEOM) begin
      cov_q    <= cov_w[23:16];
      px_q     <= gx[als_pkg::PixW-1:0];
      py_q     <= gy[als_pkg::PixW-1:0];
      plot_q   <= g_plot;
      far_ok_q <= g_far;
    end
    if (state_q == S_NEAR) begin
      near_q <= mul_p;
    end
    if (state_q == S_FAR && out_free) begin
      opx_q     <= plot_q ? px_q : '0;
      opy_q     <= plot_q ? py_q : '0;
      onear_q   <= plot_q ? near_q : '0;
      ofar_q    <= far_ok_q ? mul_p : '0;
      ofar_ok_q <= far_ok_q;
      oalong_q  <= steep_q;
      oplot_q   <= plot_q;
      olast_q   <= last_q;
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.pix_x      = opx_q;
  assign out_o.pix_y      = opy_q;
  assign out_o.near_value = onear_q;
  assign out_o.far_value  = ofar_q;
  assign out_o.far_ok     = ofar_ok_q;
  assign out_o.along_x    = oalong_q;
  assign out_o.plotted    = oplot_q;
  assign out_o.last       = olast_q;

endmodule

`default_nettype wire
